// File: rtl/core/i2d_pkg.sv
// shared types and constants for the 64-bit binary to decimal ascii converter
// no dependencies
package i2d_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned NUM_DIGITS = 20;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

endpackage

// File: rtl/core/int64_to_decimal_ascii.sv
// top level of the 64-bit binary to decimal ascii converter
// depends on i2d_pkg, i2d_front, i2d_fifo, i2d_back
//
// Each input transfer carries a 64-bit value and a mode bit (func_i = 1 reads the value as
// two's complement). The block returns its decimal text as one character per output
// transfer, most significant digit first with leading zeros dropped, a leading '-' for
// negative signed values, and last_o set on the final digit. The digit engine loads a number,
// converts it in the shift-add-3 converter (two bits a cycle), sends a minus sign if present,
// and then walks the 20 digit positions, stalling whenever the output is not taken. The front
// stage and a QUEUE_DEPTH-entry queue keep accepting numbers while the engine is busy, until
// they are full.
module int64_to_decimal_ascii #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [i2d_pkg::VALUE_W-1:0]  value_i,
  input  logic                         func_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [i2d_pkg::CHAR_W-1:0]   character_o,
  output logic                         last_o
);
  import i2d_pkg::*;

  item_t front_item;
  item_t queue_item;
  logic  push;
  logic  push_ready;
  logic  queue_valid;
  logic  pop;

  i2d_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .func_i       (func_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (front_item)
  );

  i2d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .item_i       (front_item),
    .pop_i        (pop),
    .valid_o      (queue_valid),
    .item_o       (queue_item)
  );

  i2d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (queue_valid),
    .item_i      (queue_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// File: rtl/core/i2d_front.sv
// front end: accepts values, resolves sign and magnitude, holds one item for the queue
// depends on i2d_pkg
module i2d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [i2d_pkg::VALUE_W-1:0]   value_i,
  input  logic                          func_i,
  output logic                          push_o,
  input  logic                          push_ready_i,
  output i2d_pkg::item_t                item_o
);
  import i2d_pkg::*;

  logic  stage_valid_q;
  item_t stage_q;
  item_t stage_d;
  logic  take;

  assign in_ready_o = !stage_valid_q || push_ready_i;
  assign take       = in_valid_i && in_ready_o;
  assign push_o     = stage_valid_q;
  assign item_o     = stage_q;

  always_comb begin
    stage_d.neg = func_i & value_i[VALUE_W-1];
    stage_d.mag = stage_d.neg ? (~value_i) + VALUE_W'(1) : value_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (take) begin
      stage_valid_q <= 1'b1;
    end else if (push_ready_i) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      stage_q <= stage_d;
    end
  end

endmodule

// File: rtl/core/i2d_fifo.sv
// short queue between front end and digit engine
// depends on i2d_pkg
module i2d_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           push_ready_o,
  input  i2d_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           valid_o,
  output i2d_pkg::item_t item_o
);
  import i2d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push;
  logic             do_pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o      = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("queue count above depth");

  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !valid_o) |=> valid_o) else $error("pushed item not visible");

  a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push && !push_ready_o) |=> push_ready_o)
    else $error("pop from full queue did not free a slot");

endmodule

// File: rtl/core/i2d_back.sv
// digit engine: shift-add-3 conversion, two bits a cycle, then msb-first character output
// depends on i2d_pkg
module i2d_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  i2d_pkg::item_t              item_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [i2d_pkg::CHAR_W-1:0]  character_o,
  output logic                        last_o
);
  import i2d_pkg::*;

  localparam int unsigned SR_W   = BCD_W + VALUE_W;
  localparam int unsigned STEPS  = VALUE_W / 2;
  localparam int unsigned STEP_W = $clog2(STEPS);
  localparam int unsigned REM_W  = $clog2(NUM_DIGITS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_e;

  function automatic logic [SR_W-1:0] dabble(input logic [SR_W-1:0] x);
    logic [SR_W-1:0] y;
    logic [3:0]      d;
    y = x;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = y[VALUE_W + 4*i +: 4];
      if (d >= 4'd5) begin
        y[VALUE_W + 4*i +: 4] = d + 4'd3;
      end
    end
    return {y[SR_W-2:0], 1'b0};
  endfunction

  state_e              state_q;
  logic [SR_W-1:0]     sr_q;
  logic [STEP_W-1:0]   step_q;
  logic [REM_W-1:0]    rem_q;
  logic                neg_q;
  logic                started_q;
  logic                out_valid_q;
  logic [CHAR_W-1:0]   char_q;
  logic                last_q;
  logic                adv;
  logic [3:0]          top_digit;
  logic                is_last;
  logic                char_fire;

  assign adv         = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == ST_IDLE) && valid_i;
  assign top_digit   = sr_q[SR_W-1 -: 4];
  assign is_last     = (rem_q == REM_W'(1));
  assign char_fire   = adv && ((state_q == ST_SIGN) ||
                               ((state_q == ST_EMIT) &&
                                (top_digit != 4'd0 || started_q || is_last)));
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      rem_q       <= '0;
      neg_q       <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
      sr_q        <= '0;
    end else begin
      if (char_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            sr_q      <= {{BCD_W{1'b0}}, item_i.mag};
            neg_q     <= item_i.neg;
            step_q    <= '0;
            started_q <= 1'b0;
            state_q   <= ST_CONV;
          end
        end
        ST_CONV: begin
          sr_q   <= dabble(dabble(sr_q));
          step_q <= step_q + STEP_W'(1);
          if (step_q == STEP_W'(STEPS - 1)) begin
            rem_q   <= REM_W'(NUM_DIGITS);
            state_q <= neg_q ? ST_SIGN : ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (adv) begin
            char_q      <= CHAR_MINUS;
            last_q      <= 1'b0;
            state_q     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (adv) begin
            if (top_digit != 4'd0 || started_q || is_last) begin
              char_q      <= CHAR_ZERO + {4'd0, top_digit};
              last_q      <= is_last;
              started_q   <= 1'b1;
            end
            sr_q  <= {sr_q[SR_W-5:0], 4'd0};
            rem_q <= rem_q - REM_W'(1);
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CHAR_MINUS ||
                     (character_o >= CHAR_ZERO && character_o <= CHAR_NINE)))
    else $error("character outside digit and minus set");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && character_o == CHAR_MINUS) |-> !last_o)
    else $error("minus sign marked last");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != '0 && rem_q <= REM_W'(NUM_DIGITS)))
    else $error("digit count out of range while emitting");

endmodule

// File: tb/int64_to_decimal_ascii_checker.sv
// checker for the 64-bit binary to decimal ascii converter: watches both channels,
// predicts the character run of every number taken in and compares it character by character
// depends on i2d_pkg
module int64_to_decimal_ascii_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [i2d_pkg::VALUE_W-1:0] value_i,
  input  logic                        func_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [i2d_pkg::CHAR_W-1:0]  character_i,
  input  logic                        last_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o,
  output int unsigned                 numbers_o,
  output int unsigned                 negatives_o,
  output int unsigned                 chars_o
);

  typedef struct packed {
    logic [i2d_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } text_char_t;

  text_char_t  expected_text[$];
  int unsigned fail_count = 0;
  int unsigned numbers    = 0;
  int unsigned negatives  = 0;
  int unsigned chars      = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = expected_text.size();
  assign numbers_o    = numbers;
  assign negatives_o  = negatives;
  assign chars_o      = chars;

  task automatic report_mismatch(input string what);
    $display("[%0t] converter check: %s", $time, what);
    fail_count++;
  endtask

  // decimal text of one number, minus sign first, digits most significant first
  function automatic void spell_decimal(input logic [i2d_pkg::VALUE_W-1:0] v,
                                        input logic is_signed);
    logic [i2d_pkg::VALUE_W-1:0] mag;
    logic [i2d_pkg::CHAR_W-1:0]  digits[$];
    text_char_t                  c;
    mag = v;
    if (is_signed && v[i2d_pkg::VALUE_W-1]) begin
      c.ch   = i2d_pkg::CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
      mag = ~v + 64'd1;
    end
    do begin
      digits.push_front(i2d_pkg::CHAR_ZERO + 8'(mag % 64'd10));
      mag = mag / 64'd10;
    end while (mag != 0);
    foreach (digits[i]) begin
      c.ch   = digits[i];
      c.last = (i == digits.size() - 1);
      expected_text.push_back(c);
    end
  endfunction

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        chars++;
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with nothing expected", character_i));
        end else begin
          want = expected_text.pop_front();
          if (character_i !== want.ch)
            report_mismatch($sformatf("character 0x%02h, wanted 0x%02h", character_i, want.ch));
          if (last_i !== want.last)
            report_mismatch($sformatf("last %b, wanted %b on character 0x%02h",
                                      last_i, want.last, want.ch));
        end
      end
      if (in_valid_i && in_ready_i) begin
        numbers++;
        if (func_i && value_i[i2d_pkg::VALUE_W-1]) negatives++;
        spell_decimal(value_i, func_i);
      end
    end
  end

endmodule

// File: tb/tb_int64_to_decimal_ascii.sv
// testbench top for the 64-bit binary to decimal ascii converter: directed and random numbers
// in both modes under several idle and stall mixes, verdict from the checker's failure and pending counts
// depends on i2d_pkg, int64_to_decimal_ascii, int64_to_decimal_ascii_checker
module tb_int64_to_decimal_ascii;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASE_ITEMS  = 102;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic [i2d_pkg::VALUE_W-1:0] value_i     = '0;
  logic                        func_i      = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [i2d_pkg::CHAR_W-1:0]  character_o;
  logic                        last_o;

  int unsigned fail_count, pending, numbers, negatives, chars;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;

  int64_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  int64_to_decimal_ascii_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .value_i      (value_i),
    .func_i       (func_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .character_i  (character_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .numbers_o    (numbers),
    .negatives_o  (negatives),
    .chars_o      (chars)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("int64_to_decimal_ascii: mismatch");
      $finish;
    end
  end

  function automatic logic [63:0] pow10(input int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] full;
    int          sel;
    full = {$urandom, $urandom};
    sel  = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return full;
      3, 4:    return pow10($urandom_range(0, 19)) + 64'($urandom_range(0, 4)) - 64'd2;
      5:       return 64'($urandom_range(0, 1000));
      6:       return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 6)) - 64'd3;
      7:       return full >> $urandom_range(0, 63);
      8:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
      default: return ~(full >> $urandom_range(0, 63));
    endcase
  endfunction

  task automatic send_number(input logic [63:0] v, input logic f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    func_i     <= f;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // hold the sender until every character of the numbers so far has come out
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_idle[4]  = '{0, 50, 0, 15};
    int unsigned phase_stall[4] = '{0, 0, 50, 15};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes and sign handling
    send_number(64'd0, 1'b0);
    send_number(64'd0, 1'b1);
    send_number(64'd1, 1'b0);
    send_number(64'd9, 1'b1);
    send_number(64'd10, 1'b0);
    send_number(64'd99, 1'b0);
    send_number(64'd100, 1'b1);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(64'h8000_0000_0000_0001, 1'b1);
    send_number(64'd10000000000000000000, 1'b0);
    send_number(64'd9999999999999999999, 1'b0);
    send_number(64'd999999999, 1'b0);
    send_number(64'd1000000000, 1'b1);
    send_number(-64'sd10, 1'b1);
    send_number(-64'sd10, 1'b0);
    send_number(64'd1234567890123456789, 1'b1);
    send_number(64'hFFFF_FFFF_0000_0000, 1'b1);
    send_number(64'hFFFF_FFFF_FFFF_0000, 1'b0);
    hold_until_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) send_number(pick_value(), 1'($urandom_range(0, 1)));
      hold_until_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("converted %0d numbers (%0d negative in signed mode) into %0d characters",
             numbers, negatives, chars);
    $display("under free flow, sender gaps, receiver stalls and both mixed");
    if (fail_count == 0 && pending == 0) begin
      $display("int64_to_decimal_ascii: match");
    end else begin
      $display("int64_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule
